[src/sli_pkg.sv]
`timescale 1ns / 1ps

package sli_pkg;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  // Request payload
  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] smallest;
    logic               smallest_valid;
  } rsp_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic               sample;
    logic               upd_ins;
    logic               upd_del;
    logic signed [31:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic signed [31:0] val;
    logic               valid;
    logic               ge;
  } nbr_t;

  // Next contents of a cell
  typedef struct packed {
    logic signed [31:0] val;
    logic               valid;
  } head_t;

endpackage

[src/sli_cell.sv]
`timescale 1ns / 1ps

module sli_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sli_pkg::cell_cmd_t cmd_i,
  input  sli_pkg::nbr_t     left_i,
  input  sli_pkg::nbr_t     right_i,
  output sli_pkg::nbr_t     nbr_o,
  output sli_pkg::head_t    nxt_o,
  output logic              hit_o
);

  logic signed [31:0] val_q, val_d;
  logic               valid_q, valid_d;
  logic               ge_q, ge_d;
  logic               eq_q, eq_d;

  // Compare own entry against the request value; empty cells count as above it
  always_comb begin
    ge_d = !valid_q || !(val_q < cmd_i.value);
    eq_d = valid_q && (val_q == cmd_i.value);
  end

  // Shift right on insert, shift left on delete, from the boundary on
  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (cmd_i.upd_ins && ge_q) begin
      val_d   = left_i.ge ? left_i.val : cmd_i.value;
      valid_d = valid_q | left_i.valid;
    end else if (cmd_i.upd_del && ge_q && valid_q) begin
      val_d   = right_i.val;
      valid_d = right_i.valid;
    end
  end

  // Hold entry data
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Hold valid bit and compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ge_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.sample) begin
        ge_q <= ge_d;
        eq_q <= eq_d;
      end
    end
  end

  // First cell at or above the value, and it matches
  assign hit_o = ge_q & ~left_i.ge & eq_q;

  assign nbr_o = '{val: val_q, valid: valid_q, ge: ge_q};
  assign nxt_o = '{val: val_d, valid: valid_d};

endmodule

[src/sorted_list_insert_delete.sv]
`timescale 1ns / 1ps
// Channel   Valid / Ready                Payload
// request   req_valid_i / req_ready_o    req_i (sli_pkg::req_t: op, value)
// response  rsp_valid_o / rsp_ready_i    rsp_o (sli_pkg::rsp_t)
//
// Each request runs in an accept step and an apply step: the accept edge
// latches every cell's compare flags; the apply edge, once the response
// register is free, shifts the cell row and loads the response register.
// Reset empties the row at once (valid bits and compare flags; entry data is not reset) and clears the count.
// A response not yet taken holds the row in the apply step until taken.

module sorted_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sli_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output sli_pkg::rsp_t rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sli_pkg::state_e    state_q, state_d;
  sli_pkg::req_t      req_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               rsp_valid_q;
  sli_pkg::rsp_t      rsp_q;

  sli_pkg::cell_cmd_t cmd;
  sli_pkg::nbr_t      nbr [CAPACITY];
  sli_pkg::head_t     head_nxt;
  logic [CAPACITY-1:0] hit;

  logic               accept;
  logic               go;
  logic               full;
  logic               empty;
  logic               found;
  sli_pkg::status_e   status;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sli_pkg::nbr_t left, right;
    if (i == 0) begin : g_first
      assign left = '{val: '0, valid: 1'b1, ge: 1'b0};
    end else begin : g_inner_l
      assign left = nbr[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '{val: '0, valid: 1'b0, ge: 1'b0};
    end else begin : g_inner_r
      assign right = nbr[i+1];
    end
    if (i == 0) begin : g_head
      sli_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cmd_i   (cmd),
        .left_i  (left),
        .right_i (right),
        .nbr_o   (nbr[i]),
        .nxt_o   (head_nxt),
        .hit_o   (hit[i])
      );
    end else begin : g_body
      sli_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cmd_i   (cmd),
        .left_i  (left),
        .right_i (right),
        .nbr_o   (nbr[i]),
        .nxt_o   (),
        .hit_o   (hit[i])
      );
    end
  end

  assign accept = (state_q == sli_pkg::S_IDLE) && req_valid_i;
  assign go     = (state_q == sli_pkg::S_APPLY) && (!rsp_valid_q || rsp_ready_i);
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign found  = |hit;

  // Drive the broadcast command
  always_comb begin
    cmd.sample  = accept;
    cmd.value   = (state_q == sli_pkg::S_IDLE) ? req_i.value : req_q.value;
    cmd.upd_ins = go && (req_q.op == sli_pkg::OP_INSERT) && !full;
    cmd.upd_del = go && (req_q.op == sli_pkg::OP_DELETE) && found;
  end

  // Next state, status and count
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    status  = sli_pkg::ST_OK;
    if (req_q.op == sli_pkg::OP_INSERT) begin
      if (full) status = sli_pkg::ST_FULL;
    end else if (empty) begin
      status = sli_pkg::ST_EMPTY;
    end else if (!found) begin
      status = sli_pkg::ST_NOT_FOUND;
    end
    unique case (state_q)
      sli_pkg::S_IDLE: begin
        if (accept) state_d = sli_pkg::S_APPLY;
      end
      sli_pkg::S_APPLY: begin
        if (go) begin
          state_d = sli_pkg::S_IDLE;
          if (cmd.upd_ins) count_d = count_q + CNT_W'(1);
          else if (cmd.upd_del) count_d = count_q - CNT_W'(1);
        end
      end
      default: state_d = sli_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sli_pkg::S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (go) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (go) begin
      rsp_q.status         <= status;
      rsp_q.entry_count    <= 5'(count_d);
      rsp_q.smallest       <= head_nxt.valid ? head_nxt.val : '0;
      rsp_q.smallest_valid <= head_nxt.valid;
    end
  end

  assign req_ready_o = (state_q == sli_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nbr[0].valid == (count_q != '0))
    else $error("head cell valid disagrees with count");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sli_pkg::S_APPLY) |-> $onehot0(hit))
    else $error("more than one delete boundary cell");

  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == sli_pkg::S_APPLY))
    else $error("response raised outside the apply step");

endmodule
